// ----- hdl/metd_pkg.sv -----
// ----------------------------------------------------------------------------
// metd_pkg
// Shared widths, register codes, reset values and types for the Manchester
// edge-interval decoder.
// ----------------------------------------------------------------------------
package metd_pkg;

    // timestamp arithmetic width, only the low TICK_BITS of edge_time count
    localparam int TICK_BITS = 32;

    localparam int TIME_W  = 32;
    localparam int WIN_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 3;
    localparam int CFG_IDX_W = 2;

    // compare width wide enough for both interval and window bounds
    localparam int CMP_W = (TICK_BITS > WIN_W) ? TICK_BITS : WIN_W;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_MAX  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_MAX = 2'd3;

    // register reset values
    localparam logic [WIN_W-1:0] LONG_MIN_RST  = 24'd18000;
    localparam logic [WIN_W-1:0] LONG_MAX_RST  = 24'd23000;
    localparam logic [WIN_W-1:0] SHORT_MIN_RST = 24'd8000;
    localparam logic [WIN_W-1:0] SHORT_MAX_RST = 24'd10600;

    // bit count at which the byte completes
    localparam logic [CNT_W-1:0] LAST_BIT_CNT = CNT_W'(BYTE_W - 1);

    typedef struct packed {
        logic [WIN_W-1:0] long_min;
        logic [WIN_W-1:0] long_max;
        logic [WIN_W-1:0] short_min;
        logic [WIN_W-1:0] short_max;
    } metd_cfg_t;

    typedef struct packed {
        logic is_long;
        logic is_short;
    } metd_class_t;

endpackage

// ----- hdl/metd_window_check.sv -----
// ----------------------------------------------------------------------------
// metd_window_check
// Edge interval (modulo 2^TICK_BITS) and its long / short window match.
// ----------------------------------------------------------------------------
module metd_window_check
    import metd_pkg::*;
(
    input  logic [TICK_BITS-1:0] now_time,
    input  logic [TICK_BITS-1:0] last_time,
    input  metd_cfg_t            cfg,
    output metd_class_t          cls
);

    logic [TICK_BITS-1:0] interval;
    logic [CMP_W-1:0]     ival_ext;
    logic                 long_hit;
    logic                 short_hit;

    // wraps naturally at TICK_BITS
    assign interval = now_time - last_time;
    assign ival_ext = CMP_W'(interval);

    assign long_hit  = (ival_ext >= CMP_W'(cfg.long_min))
                    && (ival_ext <= CMP_W'(cfg.long_max));
    assign short_hit = (ival_ext >= CMP_W'(cfg.short_min))
                    && (ival_ext <= CMP_W'(cfg.short_max));

    // long window wins when both match
    assign cls.is_long  = long_hit;
    assign cls.is_short = short_hit && !long_hit;

endmodule

// ----- hdl/manchester_edge_timing_decoder.sv -----
// ----------------------------------------------------------------------------
// manchester_edge_timing_decoder
// Decodes Manchester line edges by timing the interval between them and
// packs the recovered bits, first bit in the msb, into bytes.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  in        input      in_valid/in_stall   edge_time[31:0], line_level
//  out       output     out_valid/out_stall data_byte[7:0]
//  cfg       input      cfg_we              cfg_index[1:0], cfg_data[23:0]
//
// one edge word per cycle while in_stall stays low; a byte reaches the output
// through the input register, then the result register
// the feedback loop is last edge time, pair flag, bit count and shift register,
// updated by one subtract and two window compares per edge
// reset clears the pipeline valids, decoder state and restores the windows
// in_stall rises only when the input register is full and the result
// register is held by out_stall
//
module manchester_edge_timing_decoder
    import metd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // edge words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [TIME_W-1:0]    edge_time,
    input  logic                 line_level,
    // byte words
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    data_byte,
    // window registers
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data
);

    // window registers
    metd_cfg_t cfg_reg;

    // input register stage
    logic                 a_valid_reg;
    logic [TICK_BITS-1:0] a_time_reg;
    logic                 a_level_reg;

    // decoder state
    logic                 primed_reg;
    logic [TICK_BITS-1:0] last_time_reg;
    logic                 half_reg;
    logic [BYTE_W-1:0]    shift_reg;
    logic [CNT_W-1:0]     bits_reg;

    logic                 half_next;
    logic [BYTE_W-1:0]    shift_next;
    logic [CNT_W-1:0]     bits_next;

    // result register
    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    out_byte_reg;

    logic                 a_adv;
    logic                 in_take;
    logic                 have_bit;
    logic                 load_out;
    logic [BYTE_W-1:0]    new_byte;
    metd_class_t          cls;

    // input stage moves on unless the result register is full and held
    assign a_adv    = a_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = a_valid_reg && !a_adv;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign data_byte = out_byte_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_min  <= LONG_MIN_RST;
            cfg_reg.long_max  <= LONG_MAX_RST;
            cfg_reg.short_min <= SHORT_MIN_RST;
            cfg_reg.short_max <= SHORT_MAX_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LONG_MIN:  cfg_reg.long_min  <= cfg_data;
                REG_LONG_MAX:  cfg_reg.long_max  <= cfg_data;
                REG_SHORT_MIN: cfg_reg.short_min <= cfg_data;
                REG_SHORT_MAX: cfg_reg.short_max <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (a_adv)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_time_reg  <= edge_time[TICK_BITS-1:0];
            a_level_reg <= line_level;
        end
    end

    metd_window_check u_window (
        .now_time  (a_time_reg),
        .last_time (last_time_reg),
        .cfg       (cfg_reg),
        .cls       (cls)
    );

    // bit recovery: long gives a bit, second short of a pair gives a bit
    // long leaves the pair flag alone
    always_comb
    begin
        have_bit   = 1'b0;
        half_next  = half_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        load_out   = 1'b0;
        new_byte   = {shift_reg[BYTE_W-2:0], a_level_reg};
        if (primed_reg)
        begin
            if (cls.is_long)
            begin
                have_bit = 1'b1;
            end
            else if (cls.is_short)
            begin
                have_bit  = half_reg;
                half_next = !half_reg;
            end
        end
        if (have_bit)
        begin
            if (bits_reg == LAST_BIT_CNT)
            begin
                load_out   = 1'b1;
                shift_next = '0;
                bits_next  = '0;
            end
            else
            begin
                shift_next = new_byte;
                bits_next  = bits_reg + CNT_W'(1);
            end
        end
    end

    // decoder state, first edge only primes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            last_time_reg <= '0;
            half_reg      <= 1'b0;
            shift_reg     <= '0;
            bits_reg      <= '0;
        end
        else if (a_adv)
        begin
            primed_reg    <= 1'b1;
            last_time_reg <= a_time_reg;
            half_reg      <= half_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (a_adv && load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && load_out)
        begin
            out_byte_reg <= new_byte;
        end
    end

`ifndef NO_ASSERTIONS
    // a completed byte always restarts the assembly
    a_byte_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (a_adv && load_out) |=> (bits_reg == '0 && shift_reg == '0))
        else $error("byte assembly not restarted after output");

    // nothing is collected before the first edge
    a_unprimed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> (bits_reg == '0 && !half_reg))
        else $error("decoder state moved before first edge");

    // backpressure only with a full input stage behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (a_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a held result");

    // first processed edge primes the decoder
    a_primes: assert property (@(posedge clk) disable iff (!rst_n)
        (a_adv && !primed_reg) |=> (primed_reg && !out_valid_reg))
        else $error("first edge did not prime or produced a byte");
`endif

endmodule

// ----- tb/metd_byte_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// metd_byte_checker
// Watches the edge, byte and window-register ports of the Manchester decoder,
// decodes every accepted edge word on its own, and compares each byte that
// leaves the block with the oldest byte it expects.
// ----------------------------------------------------------------------------
module metd_byte_checker
    import metd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [TIME_W-1:0]    edge_time,
    input  logic                 line_level,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [BYTE_W-1:0]    data_byte,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIN_W-1:0]     cfg_data,
    input  logic                 at_end,
    output int                   failures,
    output int                   pending,
    output int                   bytes_checked
);

    localparam logic [TIME_W-1:0] TICK_MASK =
        (TICK_BITS >= TIME_W) ? '1 : TIME_W'((64'd1 << TICK_BITS) - 64'd1);

    metd_cfg_t          win;
    logic               primed;
    logic [TIME_W-1:0]  prev_time;
    logic               half_seen;
    logic [BYTE_W-1:0]  shift;
    logic [CNT_W-1:0]   nbits;
    logic [BYTE_W-1:0]  bytes_due[$];

    function automatic logic in_band(logic [TIME_W-1:0] span, logic [WIN_W-1:0] lo,
                                     logic [WIN_W-1:0] hi);
        return span >= TIME_W'(lo) && span <= TIME_W'(hi);
    endfunction

    task automatic decode_edge(input logic [TIME_W-1:0] stamp, input logic lvl);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] span;
        logic              take;
        now  = stamp & TICK_MASK;
        take = 1'b0;
        if (!primed) begin
            // first edge only primes the timer
            primed    = 1'b1;
            prev_time = now;
        end
        else begin
            span      = (now - prev_time) & TICK_MASK;
            prev_time = now;
            if (in_band(span, win.long_min, win.long_max))
                take = 1'b1;
            else if (in_band(span, win.short_min, win.short_max)) begin
                take      = half_seen;
                half_seen = !half_seen;
            end
        end
        if (take) begin
            shift = {shift[BYTE_W-2:0], lvl};
            if (nbits == LAST_BIT_CNT) begin
                bytes_due.push_back(shift);
                shift = '0;
                nbits = '0;
            end
            else
                nbits = nbits + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            win           = '{LONG_MIN_RST, LONG_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST};
            primed        = 1'b0;
            prev_time     = '0;
            half_seen     = 1'b0;
            shift         = '0;
            nbits         = '0;
            bytes_due.delete();
            failures      = 0;
            pending       = 0;
            bytes_checked = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_LONG_MIN:  win.long_min  = cfg_data;
                    REG_LONG_MAX:  win.long_max  = cfg_data;
                    REG_SHORT_MIN: win.short_min = cfg_data;
                    REG_SHORT_MAX: win.short_max = cfg_data;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (bytes_due.size() == 0) begin
                    $display("[%0t] data_byte with none expected: expected none, actual %02h",
                             $time, data_byte);
                    failures++;
                end
                else begin
                    if (data_byte !== bytes_due[0]) begin
                        $display("[%0t] data_byte mismatch: expected %02h, actual %02h",
                                 $time, bytes_due[0], data_byte);
                        failures++;
                    end
                    void'(bytes_due.pop_front());
                    bytes_checked++;
                end
            end
            if (in_valid && !in_stall)
                decode_edge(edge_time, line_level);
            if (at_end) begin
                while (bytes_due.size() > 0) begin
                    $display("[%0t] data_byte never arrived: expected %02h, actual none",
                             $time, bytes_due[0]);
                    failures++;
                    void'(bytes_due.pop_front());
                end
            end
            pending = bytes_due.size();
        end
    end

endmodule

// ----- tb/manchester_edge_timing_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// manchester_edge_timing_decoder_tb
// Feeds timed line edges into the decoder under a series of window settings,
// from the reset windows through overlapping, empty and full-range windows to
// random ones, with bursty input and a stalling receiver; the checker beside
// the block decodes the same edges and compares every byte.
// ----------------------------------------------------------------------------
module manchester_edge_timing_decoder_tb;
    import metd_pkg::*;

    // generous cycle budget, far beyond the slowest legal run
    localparam int RUN_LIMIT   = 400000;
    // long receiver hold-off, enough to fill both pipeline stages
    localparam int HOLD_CYCLES = 150;
    // settle time after the last byte, covers both pipeline stages
    localparam int SETTLE      = 8;
    localparam int DRAIN_CAP   = 20000;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic [TIME_W-1:0]    edge_time  = '0;
    logic                 line_level = 1'b0;
    logic                 out_stall  = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index  = REG_LONG_MIN;
    logic [WIN_W-1:0]     cfg_data   = '0;
    logic                 at_end     = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    logic [BYTE_W-1:0]    data_byte;

    int failures;
    int pending;
    int bytes_checked;

    int cycles        = 0;
    int edges_sent    = 0;
    int settings_used = 0;
    int hold_requests = 0;
    int burst_left    = 0;
    bit sender_gaps   = 1'b1;

    // our own copy of the windows, used to aim intervals at them
    metd_cfg_t         bands;
    logic [TIME_W-1:0] now_time;

    // directed intervals after the priming edge, reset windows assumed:
    // wrap through zero, both long edges, just outside both windows,
    // a long between the two shorts of a pair, zero and all-ones intervals,
    // then a short pair and longs that close the first byte, and one byte of zeros
    logic [TIME_W-1:0] probe_gap [24] = '{
        32'd18000, 32'd23000, 32'd23001, 32'd17999, 32'd8000, 32'd23000,
        32'd10600, 32'd7999, 32'd10601, 32'd0, 32'hFFFF_FFFF, 32'd10000,
        32'd9000, 32'd20000, 32'd20000, 32'd20000,
        32'd18000, 32'd19000, 32'd20000, 32'd21000, 32'd22000, 32'd23000,
        32'd18500, 32'd22500
    };
    logic [23:0] probe_level = 24'b1110_1100_0111_1111_0000_0000;

    // ------------------------------------------------------------------
    // clock, timeout
    // ------------------------------------------------------------------
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bytes still expected", cycles, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // block and checker
    // ------------------------------------------------------------------
    manchester_edge_timing_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .edge_time  (edge_time),
        .line_level (line_level),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_byte  (data_byte),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    metd_byte_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .edge_time     (edge_time),
        .line_level    (line_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .data_byte     (data_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .at_end        (at_end),
        .failures      (failures),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    // ------------------------------------------------------------------
    // receiver: stall patterns in random stretches, plus long hold-offs
    // on request from the stimulus
    // ------------------------------------------------------------------
    initial
    begin
        int       hold_left;
        int       served;
        int       mode;
        int       mode_left;
        bit [1:0] beat;
        hold_left = 0;
        served    = 0;
        mode      = 0;
        mode_left = 0;
        beat      = '0;
        forever
        begin
            @(posedge clk);
            if (served != hold_requests)
            begin
                served    = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                // hold off while the sender keeps pushing, so in_stall rises
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                beat++;
                case (mode)
                    0: out_stall <= 1'b0;                          // free flow
                    1: out_stall <= ($urandom_range(0, 99) < 30);  // light stalls
                    2: out_stall <= (beat == 2'd3);                // stall whenever the beat counter reads 3
                    default: out_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one edge word, with a random gap at the start of each burst
    task automatic send_edge(input logic [TIME_W-1:0] stamp, input logic lvl);
        int gap;
        if (burst_left == 0)
        begin
            gap        = sender_gaps ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid   <= 1'b1;
        edge_time  <= stamp;
        line_level <= lvl;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        edges_sent++;
    endtask

    task automatic advance_edge(input logic [TIME_W-1:0] span, input logic lvl);
        now_time = now_time + span;
        send_edge(now_time, lvl);
    endtask

    // stop offering, wait for every expected byte, then let the pipe settle
    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_CAP)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // write all four windows on consecutive cycles, block idle
    task automatic set_bands(input logic [WIN_W-1:0] lmin, input logic [WIN_W-1:0] lmax,
                             input logic [WIN_W-1:0] smin, input logic [WIN_W-1:0] smax);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LONG_MIN;
        cfg_data  <= lmin;
        @(posedge clk);
        cfg_index <= REG_LONG_MAX;
        cfg_data  <= lmax;
        @(posedge clk);
        cfg_index <= REG_SHORT_MIN;
        cfg_data  <= smin;
        @(posedge clk);
        cfg_index <= REG_SHORT_MAX;
        cfg_data  <= smax;
        @(posedge clk);
        cfg_we <= 1'b0;
        bands = '{lmin, lmax, smin, smax};
        settings_used++;
    endtask

    // uniform pick inside a window, anything at all if the window is empty
    function automatic logic [TIME_W-1:0] band_pick(logic [WIN_W-1:0] lo,
                                                    logic [WIN_W-1:0] hi);
        if (lo > hi)
            return $urandom;
        return TIME_W'(lo) + TIME_W'($urandom_range(0, hi - lo));
    endfunction

    // mostly well-formed long and short intervals, some window edges, some noise
    function automatic logic [TIME_W-1:0] next_interval();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return band_pick(bands.long_min, bands.long_max);
        if (roll < 85)
            return band_pick(bands.short_min, bands.short_max);
        if (roll < 93)
        begin
            case ($urandom_range(0, 7))
                0: return TIME_W'(bands.long_min);
                1: return TIME_W'(bands.long_max);
                2: return TIME_W'(bands.long_min) - 1'b1;
                3: return TIME_W'(bands.long_max) + 1'b1;
                4: return TIME_W'(bands.short_min);
                5: return TIME_W'(bands.short_max);
                6: return TIME_W'(bands.short_min) - 1'b1;
                default: return TIME_W'(bands.short_max) + 1'b1;
            endcase
        end
        return $urandom;
    endfunction

    // one run of random edges; hold_at picks the edge that asks for a hold-off
    task automatic run_phase(input int count, input int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_requests++;
            advance_edge(next_interval(), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [WIN_W-1:0] smin;
        logic [WIN_W-1:0] smax;
        logic [WIN_W-1:0] lmin;
        logic [WIN_W-1:0] lmax;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        bands = '{LONG_MIN_RST, LONG_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST};

        // directed part under the reset windows; priming edge sits just
        // below the timestamp wrap
        now_time = 32'hFFFF_F000;
        send_edge(now_time, 1'b0);
        foreach (probe_gap[i])
            advance_edge(probe_gap[i], probe_level[23 - i]);
        drain();

        // overlapping windows, long one wins; long hold-off early on
        set_bands(24'd5000, 24'd30000, SHORT_MIN_RST, SHORT_MAX_RST);
        run_phase(200, 30);
        drain();

        // full range windows, no sender gaps
        sender_gaps = 1'b0;
        set_bands('0, '1, '0, '1);
        run_phase(150, -1);
        drain();

        // empty long window, narrow short one
        sender_gaps = 1'b1;
        set_bands('1, '0, 24'd100, 24'd200);
        run_phase(150, -1);
        drain();

        // tiny long window, empty short window
        set_bands(24'd40, 24'd60, 24'd30, 24'd20);
        run_phase(150, -1);
        drain();

        // windows at the very top of the register range
        set_bands(24'hFFFF00, '1, 24'hFFFE00, 24'hFFFEFF);
        run_phase(100, -1);
        drain();

        // back to the reset windows, second hold-off
        set_bands(LONG_MIN_RST, LONG_MAX_RST, SHORT_MIN_RST, SHORT_MAX_RST);
        run_phase(200, 50);
        drain();

        // random bit rates, long window near twice the short one
        for (int k = 0; k < 5; k++)
        begin
            sender_gaps = (k != 3);
            smin = WIN_W'($urandom_range(1, 1 << 20));
            smax = smin + WIN_W'($urandom_range(0, smin / 4));
            lmin = WIN_W'(2 * smin) - WIN_W'($urandom_range(0, smin / 4));
            lmax = WIN_W'(2 * smax) + WIN_W'($urandom_range(0, smin / 2));
            set_bands(lmin, lmax, smin, smax);
            run_phase(140, (k == 2) ? 40 : -1);
            drain();
        end

        at_end <= 1'b1;
        @(posedge clk);
        at_end <= 1'b0;
        @(posedge clk);

        $display("covered %0d edge words under %0d window settings, %0d long hold-offs",
                 edges_sent, settings_used + 1, hold_requests);
        $display("%0d decoded bytes compared, %0d failures", bytes_checked, failures);
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
